@@ hw/rtl/cpt_pkg.sv @@
package cpt_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_WIDTH  = 16;

  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int CFG_W  = 7;
  localparam int IDX_W  = 6;
  localparam int ID_W   = 8;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int MIN_VERTICES = 3;
  localparam int VCOUNT_RESET = 3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_DIFF,
    ST_MUL1,
    ST_MUL2,
    ST_CMP
  } state_t;

endpackage

@@ hw/rtl/cpt_ram.sv @@
module cpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/convex_polygon_point_test_core.sv @@
// Channel  Direction  Handshake                Payload
// in_      input      in_valid / in_stall      op, vertex_index, coord_x, coord_y, point_id
// out_     output     out_valid / out_stall    result_id, inside_res
// cfg_     input      cfg_wr_en                cfg_wr_data (vertex_count)
//
// Load items are taken back to back while the sequencer is idle. A query first
// fetches vertex 0, then walks the edges through one shared multiplier, each edge
// passing the DIFF, MUL1, MUL2 and CMP steps, and stops early at the first edge
// that puts the point outside. Reset clears the sequencer and the result valid flag
// and sets vertex_count to 3; the vertex store is not cleared.
// A waiting result does not block loads; a query that finishes while its
// predecessor is still stalled holds in its last step until the output frees.
module convex_polygon_point_test_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic [cpt_pkg::IDX_W-1:0]  in_vertex_index,
  input  cpt_pkg::coord_t            in_coord_x,
  input  cpt_pkg::coord_t            in_coord_y,
  input  logic [cpt_pkg::ID_W-1:0]   in_point_id,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cpt_pkg::ID_W-1:0]   out_result_id,
  output logic                       out_inside_res,
  input  logic                       cfg_wr_en,
  input  logic [cpt_pkg::CFG_W-1:0]  cfg_wr_data
);
  import cpt_pkg::*;

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    vcount_r, vcount_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic                out_inside_r, out_inside_nxt;

  cnt_t                n_r, n_nxt;
  cnt_t                k_r, k_nxt;
  coord_t              qx_r, qx_nxt, qy_r, qy_nxt;
  logic [ID_W-1:0]     qid_r, qid_nxt;
  coord_t              first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  coord_t              prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  diff_t               ex_r, ex_nxt, ey_r, ey_nxt, px_r, px_nxt, py_r, py_nxt;
  prod_t               prod_r, prod_nxt, hold_r, hold_nxt;

  logic                ram_wr_en;
  logic [2*COORD_WIDTH-1:0] ram_rd_data;
  coord_t              rd_x, rd_y, cur_x, cur_y;
  diff_t               mul_a, mul_b;
  cnt_t                n_clamp;
  logic                in_acc, out_acc;

  cpt_ram #(
    .WIDTH (2 * COORD_WIDTH),
    .DEPTH (MAX_VERTICES)
  ) u_vertex_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ADDR_W'(in_vertex_index)),
    .wr_data ({in_coord_y, in_coord_x}),
    .rd_addr (ADDR_W'(k_nxt)),
    .rd_data (ram_rd_data)
  );

  assign rd_x = ram_rd_data[COORD_WIDTH-1:0];
  assign rd_y = ram_rd_data[2*COORD_WIDTH-1:COORD_WIDTH];

  assign in_stall       = (state_r != ST_IDLE);
  assign in_acc         = in_valid && !in_stall;
  assign out_acc        = out_valid_r && !out_stall;
  assign out_valid      = out_valid_r;
  assign out_result_id  = out_id_r;
  assign out_inside_res = out_inside_r;

  // saturate the vertex count into the supported range
  always_comb begin
    if (int'(vcount_r) < MIN_VERTICES) begin
      n_clamp = CNT_W'(MIN_VERTICES);
    end else if (int'(vcount_r) > MAX_VERTICES) begin
      n_clamp = CNT_W'(MAX_VERTICES);
    end else begin
      n_clamp = CNT_W'(vcount_r);
    end
  end

  // closing edge ends at vertex 0
  assign cur_x = (k_r == n_r) ? first_x_r : rd_x;
  assign cur_y = (k_r == n_r) ? first_y_r : rd_y;

  assign mul_a    = (state_r == ST_MUL1) ? ex_r : ey_r;
  assign mul_b    = (state_r == ST_MUL1) ? py_r : px_r;
  assign prod_nxt = prod_t'(mul_a) * prod_t'(mul_b);

  assign ram_wr_en = in_acc && (in_op == OP_LOAD) &&
                     (int'(in_vertex_index) < MAX_VERTICES);

  always_comb begin
    state_nxt      = state_r;
    vcount_nxt     = cfg_wr_en ? cfg_wr_data : vcount_r;
    out_valid_nxt  = out_acc ? 1'b0 : out_valid_r;
    out_id_nxt     = out_id_r;
    out_inside_nxt = out_inside_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    qx_nxt         = qx_r;
    qy_nxt         = qy_r;
    qid_nxt        = qid_r;
    first_x_nxt    = first_x_r;
    first_y_nxt    = first_y_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    ex_nxt         = ex_r;
    ey_nxt         = ey_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    hold_nxt       = hold_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_op == OP_QUERY)) begin
          qx_nxt    = in_coord_x;
          qy_nxt    = in_coord_y;
          qid_nxt   = in_point_id;
          n_nxt     = n_clamp;
          k_nxt     = '0;
          state_nxt = ST_FIRST;
        end
      end
      ST_FIRST: begin
        first_x_nxt = rd_x;
        first_y_nxt = rd_y;
        prev_x_nxt  = rd_x;
        prev_y_nxt  = rd_y;
        k_nxt       = CNT_W'(1);
        state_nxt   = ST_DIFF;
      end
      ST_DIFF: begin
        ex_nxt     = diff_t'(cur_x) - diff_t'(prev_x_r);
        ey_nxt     = diff_t'(cur_y) - diff_t'(prev_y_r);
        px_nxt     = diff_t'(qx_r) - diff_t'(prev_x_r);
        py_nxt     = diff_t'(qy_r) - diff_t'(prev_y_r);
        prev_x_nxt = cur_x;
        prev_y_nxt = cur_y;
        state_nxt  = ST_MUL1;
      end
      ST_MUL1: begin
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        hold_nxt  = prod_r;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // positive cross product: point is outside this edge
        if ((hold_r > prod_r) || (k_r == n_r)) begin
          if (!out_valid_r || !out_stall) begin
            out_valid_nxt  = 1'b1;
            out_id_nxt     = qid_r;
            out_inside_nxt = !(hold_r > prod_r);
            state_nxt      = ST_IDLE;
          end
        end else begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = ST_DIFF;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcount_r    <= CFG_W'(VCOUNT_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_id_r     <= out_id_nxt;
    out_inside_r <= out_inside_nxt;
    n_r          <= n_nxt;
    k_r          <= k_nxt;
    qx_r         <= qx_nxt;
    qy_r         <= qy_nxt;
    qid_r        <= qid_nxt;
    first_x_r    <= first_x_nxt;
    first_y_r    <= first_y_nxt;
    prev_x_r     <= prev_x_nxt;
    prev_y_r     <= prev_y_nxt;
    ex_r         <= ex_nxt;
    ey_r         <= ey_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    prod_r       <= prod_nxt;
    hold_r       <= hold_nxt;
  end

endmodule
